// File: src/ps2kbd_pkg.sv
// ----------------------------------------------------------------------------
// ps2kbd_pkg
// Shared types, byte codes and scan code tables of the PS/2 keyboard device.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

    typedef enum logic [2:0] {
        MODE_KEY   = 3'd0,
        MODE_CMD   = 3'd1,
        MODE_READ  = 3'd2,
        MODE_RESET = 3'd3,
        MODE_SET   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CFG_KBD_TYPE = 2'd0,
        CFG_DELAY    = 2'd1,
        CFG_REPEAT   = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ARG_NONE = 2'd0,
        ARG_LED  = 2'd1,
        ARG_SET  = 2'd2,
        ARG_RATE = 2'd3
    } t_arg;

    localparam logic [7:0] BYTE_ACK    = 8'hfa;
    localparam logic [7:0] BYTE_BREAK  = 8'hf0;
    localparam logic [7:0] BYTE_BAT    = 8'haa;
    localparam logic [7:0] BYTE_ID0    = 8'hab;
    localparam logic [7:0] BYTE_ID_MF2 = 8'h41;
    localparam logic [7:0] BYTE_ID_AT  = 8'h83;
    localparam logic [7:0] BYTE_ECHO   = 8'hee;
    localparam logic [7:0] BYTE_EXT    = 8'he0;
    localparam logic [7:0] BYTE_RELB   = 8'h80;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;

    localparam logic [7:0] CMD_LED    = 8'hed;
    localparam logic [7:0] CMD_ECHO   = 8'hee;
    localparam logic [7:0] CMD_SET    = 8'hf0;
    localparam logic [7:0] CMD_ID     = 8'hf2;
    localparam logic [7:0] CMD_RATE   = 8'hf3;
    localparam logic [7:0] CMD_ENA    = 8'hf4;
    localparam logic [7:0] CMD_DIS    = 8'hf5;
    localparam logic [7:0] CMD_DEF    = 8'hf6;
    localparam logic [7:0] CMD_RESEND = 8'hfe;
    localparam logic [7:0] CMD_RESET  = 8'hff;

    localparam logic [6:0] KEY_NUMLOCK = 7'h45;
    localparam logic [6:0] KEY_EXT_LO  = 7'h60;

    function automatic logic [7:0] f_set23(input logic [6:0] k);
        logic [7:0] t [0:105];
        t = '{
            8'h00,8'h76,8'h16,8'h1e,8'h26,8'h25,8'h2e,8'h36,8'h3d,8'h3e,8'h46,8'h45,
            8'h4e,8'h55,8'h66,8'h0d,8'h15,8'h1d,8'h24,8'h2d,8'h2c,8'h35,8'h3c,8'h43,
            8'h44,8'h4d,8'h54,8'h5b,8'h5a,8'h14,8'h1c,8'h1b,8'h23,8'h2b,8'h34,8'h33,
            8'h3b,8'h42,8'h4b,8'h4c,8'h52,8'h0e,8'h12,8'h5d,8'h1a,8'h22,8'h21,8'h2a,
            8'h32,8'h31,8'h3a,8'h41,8'h49,8'h4a,8'h59,8'h00,8'h11,8'h29,8'h58,8'h05,
            8'h06,8'h04,8'h0c,8'h03,8'h0b,8'h83,8'h0a,8'h01,8'h09,8'h77,8'h7e,8'h6c,
            8'h75,8'h7d,8'h7b,8'h6b,8'h73,8'h74,8'h79,8'h69,8'h72,8'h7a,8'h70,8'h71,
            8'h00,8'h00,8'h78,8'h07,8'h5a,8'h14,8'h4a,8'h00,8'h11,8'h6c,8'h75,8'h7d,
            8'h6b,8'h74,8'h69,8'h72,8'h7a,8'h70,8'h71,8'h00,8'h00,8'h00};
        if (k > 7'd105) return 8'h00;
        return t[k];
    endfunction

    function automatic logic [7:0] f_mf2(input logic [3:0] e);
        case (e)
            4'd0: return 8'h1c;  4'd1: return 8'h1d;  4'd2: return 8'h35;
            4'd3: return 8'h37;  4'd4: return 8'h38;  4'd5: return 8'h47;
            4'd6: return 8'h48;  4'd7: return 8'h49;  4'd8: return 8'h4b;
            4'd9: return 8'h4d;  4'd10: return 8'h4f; 4'd11: return 8'h50;
            4'd12: return 8'h51; 4'd13: return 8'h52; 4'd14: return 8'h53;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] f_ext23(input logic [3:0] e);
        case (e)
            4'd0: return 8'h5a;  4'd1: return 8'h14;  4'd2: return 8'h4a;
            4'd4: return 8'h11;  4'd5: return 8'h6c;  4'd6: return 8'h75;
            4'd7: return 8'h7d;  4'd8: return 8'h6b;  4'd9: return 8'h74;
            4'd10: return 8'h69; 4'd11: return 8'h72; 4'd12: return 8'h7a;
            4'd13: return 8'h70; 4'd14: return 8'h71;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] f_pause1(input logic [2:0] i);
        case (i)
            3'd0: return 8'he0; 3'd1: return 8'h2a; 3'd2: return 8'he1;
            3'd3: return 8'h1d; 3'd4: return 8'h45; 3'd5: return 8'he1;
            3'd6: return 8'h9d; default: return 8'hc5;
        endcase
    endfunction

    function automatic logic [7:0] f_pause23(input logic [2:0] i);
        case (i)
            3'd0: return 8'he1; 3'd1: return 8'h14; 3'd2: return 8'h77;
            3'd3: return 8'he1; 3'd4: return 8'hf0; 3'd5: return 8'h14;
            3'd6: return 8'hf0; default: return 8'h77;
        endcase
    endfunction

    function automatic logic [7:0] f_prtsc(input logic [1:0] i);
        case (i)
            2'd0: return 8'he0; 2'd1: return 8'h12;
            2'd2: return 8'he0; default: return 8'h7c;
        endcase
    endfunction

endpackage

// File: src/ps2_keyboard_device_unit.sv
// ----------------------------------------------------------------------------
// ps2_keyboard_device_unit
// PS/2 keyboard device: typematic key scanning, host commands, output queue.
// ----------------------------------------------------------------------------
// An item goes from S_IDLE through S_READ and S_DECIDE to S_PUSH, which repeats for
// each byte it queues, dropped bytes included (up to 8 bytes), and then to S_OUT;
// a host read queues none. The result beat is held in S_OUT while i_ready is low. Per-key hold
// counters live in a 128-entry memory and the output queue in a FIFO_DEPTH-entry
// memory, each with a registered read. After reset a clearing pass walks the hold
// memory before the first item is taken; a keyboard reset item walks it again
// after its result beat. Queued bytes are written one per cycle by the sequencer.
module ps2_keyboard_device_unit
    import ps2kbd_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_mode,
    input  logic [6:0] i_key_index,
    input  logic       i_key_down,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_read_valid,
    output logic [7:0] o_queue_level,
    output logic       o_led_scroll,
    output logic       o_led_num,
    output logic       o_led_caps,
    output logic       o_scanning_on,
    output logic       o_numlock_mode,
    output logic [6:0] o_active_set,
    output logic       o_overflow,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH - 1);
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_PUSH, S_OUT
    } t_state;

    t_state r_state;
    logic [7:0] r_fifo [0:FIFO_DEPTH-1];
    logic [7:0] r_hold [0:127];

    logic       r_kbd_type;
    logic [7:0] r_delay;
    logic [5:0] r_repeat;

    logic [AW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    t_arg       r_arg;
    logic [6:0] r_set;
    logic       r_enabled, r_num, r_drop;
    logic [2:0] r_led;
    logic [6:0] r_clr;

    logic [2:0] r_mode;
    logic [6:0] r_key;
    logic       r_down;
    logic [7:0] r_data;
    logic [7:0] r_hrd;
    logic [7:0] r_frd;

    logic [7:0] r_seq [0:7];
    logic [3:0] r_len, r_idx;
    logic [7:0] r_rdata;
    logic       r_rvalid;

    logic       hold_we;
    logic [6:0] hold_wa;
    logic [7:0] hold_wd;
    logic       fifo_we;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);
    assign o_valid     = (r_state == S_OUT);
    assign o_read_data   = r_rdata;
    assign o_read_valid  = r_rvalid;
    assign o_queue_level = (r_count > CW'(255)) ? 8'hff : 8'(r_count);
    assign o_led_scroll  = r_led[0];
    assign o_led_num     = r_led[1];
    assign o_led_caps    = r_led[2];
    assign o_scanning_on = r_enabled;
    assign o_numlock_mode = r_num;
    assign o_active_set  = r_set;
    assign o_overflow    = r_drop;

    assign fifo_we = (r_state == S_PUSH) && (r_idx != r_len) && (r_count < FULL);

    always_ff @(posedge i_clk) begin
        r_hrd <= r_hold[r_key];
        r_frd <= r_fifo[r_tail];
        if (hold_we) r_hold[hold_wa] <= hold_wd;
        if (fifo_we) r_fifo[r_head] <= r_seq[r_idx[2:0]];
    end

    // Decide the bytes, the next hold count and the state updates for one item.
    logic [7:0] d_seq [0:7];
    logic [3:0] d_len;
    logic       d_hold_we;
    logic [7:0] d_hold;
    logic       d_clear, d_ena_set, d_ena, d_num_flip, d_led_we, d_set_we;
    logic [2:0] d_led;
    logic [6:0] d_set;
    t_arg       d_arg;

    always_comb begin
        logic       ext, press, send, runc, is1, is23;
        logic [3:0] e;
        logic [7:0] h, sc, mb;
        logic [8:0] dr;
        for (int i = 0; i < 8; i++) d_seq[i] = 8'h00;
        d_len = 4'd0; d_hold_we = 1'b0; d_hold = 8'h00; d_clear = 1'b0;
        d_ena_set = 1'b0; d_ena = r_enabled; d_num_flip = 1'b0; d_led_we = 1'b0;
        d_led = r_data[2:0];
        d_set_we = 1'b0; d_set = r_set; d_arg = r_arg;
        ext = (r_key[6:4] == KEY_EXT_LO[6:4]);
        e = r_key[3:0];
        is1 = (r_set == 7'd1);
        is23 = (r_set == 7'd2) || (r_set == 7'd3);
        send = 1'b0; press = 1'b1; h = r_hrd; runc = 1'b0;
        dr = {1'b0, r_delay} + {3'b0, r_repeat};
        sc = 8'h00; mb = f_mf2(e);
        if (r_mode == MODE_KEY && r_enabled && r_key != 7'd0) begin
            if (r_down) begin
                if (r_hrd == 8'd0) begin
                    h = 8'd1; send = 1'b1;
                    d_num_flip = !ext && (r_key == KEY_NUMLOCK);
                end else begin
                    h = r_hrd + 8'd1;
                    if (h == r_delay) send = 1'b1;
                    else if ({1'b0, h} == dr) begin h = r_delay; send = 1'b1; end
                end
                d_hold_we = 1'b1; d_hold = h;
            end else if (r_hrd != 8'd0) begin
                d_hold_we = 1'b1; d_hold = 8'd0; send = 1'b1; press = 1'b0;
            end
            if (send) begin
                if (!ext) begin
                    if (is1) begin
                        d_seq[0] = {!press, r_key}; d_len = 4'd1;
                    end else if (is23) begin
                        sc = f_set23(r_key);
                        if (press) begin d_seq[0] = sc; d_len = 4'd1; end
                        else begin d_seq[0] = BYTE_BREAK; d_seq[1] = sc; d_len = 4'd2; end
                    end else begin
                        d_seq[0] = {1'b0, r_key}; d_len = 4'd1;
                    end
                end else if (is1) begin
                    if (e == 4'd15) begin
                        if (press) begin
                            if (r_num) begin
                                for (int i = 0; i < 8; i++) d_seq[i] = f_pause1(3'(i));
                                d_len = 4'd8;
                            end else begin
                                for (int i = 0; i < 6; i++) d_seq[i] = f_pause1(3'(i + 2));
                                d_len = 4'd6;
                            end
                        end
                    end else if (r_num && e >= 4'd5) begin
                        d_len = 4'd4;
                        if (press) begin
                            d_seq[0] = BYTE_EXT; d_seq[1] = 8'h2a;
                            d_seq[2] = BYTE_EXT; d_seq[3] = mb;
                        end else begin
                            d_seq[0] = BYTE_EXT; d_seq[1] = mb | BYTE_RELB;
                            d_seq[2] = BYTE_EXT; d_seq[3] = BYTE_BAT;
                        end
                    end else begin
                        d_seq[0] = BYTE_EXT; d_seq[1] = press ? mb : (mb | BYTE_RELB);
                        d_len = 4'd2;
                    end
                end else if (is23) begin
                    if (e == 4'd15) begin
                        if (press) begin
                            for (int i = 0; i < 8; i++) d_seq[i] = f_pause23(3'(i));
                            d_len = 4'd8;
                        end
                    end else if (e == 4'd3) begin
                        if (press) begin
                            for (int i = 0; i < 4; i++) d_seq[i] = f_prtsc(2'(i));
                            d_len = 4'd4;
                        end
                    end else begin
                        d_seq[0] = BYTE_EXT;
                        if (press) begin d_seq[1] = f_ext23(e); d_len = 4'd2; end
                        else begin
                            d_seq[1] = BYTE_BREAK; d_seq[2] = f_ext23(e); d_len = 4'd3;
                        end
                    end
                end
            end
        end else if (r_mode == MODE_CMD) begin
            if (r_arg == ARG_NONE) runc = 1'b1;
            else begin
                d_arg = ARG_NONE;
                if (r_data[7]) runc = 1'b1;
                else if (r_arg == ARG_LED) begin
                    d_seq[0] = BYTE_ACK; d_len = 4'd1; d_led_we = 1'b1;
                end else if (r_arg == ARG_SET) begin
                    if (r_data == 8'd0) begin d_seq[0] = {1'b0, r_set}; d_len = 4'd1; end
                    else begin d_set_we = 1'b1; d_set = r_data[6:0]; end
                end
            end
            if (runc) begin
                unique case (r_data)
                    CMD_LED: begin d_seq[0] = BYTE_ACK; d_len = 4'd1; d_arg = ARG_LED; end
                    CMD_ECHO: begin d_seq[0] = BYTE_ECHO; d_len = 4'd1; end
                    CMD_SET: begin
                        d_clear = 1'b1; d_seq[0] = BYTE_ACK; d_len = 4'd1; d_arg = ARG_SET;
                    end
                    CMD_ID: begin
                        d_seq[0] = BYTE_ACK; d_seq[1] = BYTE_ID0;
                        d_seq[2] = r_kbd_type ? BYTE_ID_AT : BYTE_ID_MF2; d_len = 4'd3;
                    end
                    CMD_RATE: begin d_seq[0] = BYTE_ACK; d_len = 4'd1; d_arg = ARG_RATE; end
                    CMD_ENA, CMD_DEF: begin
                        d_clear = 1'b1; d_seq[0] = BYTE_ACK; d_len = 4'd1;
                        d_ena_set = 1'b1; d_ena = 1'b1;
                    end
                    CMD_DIS: begin
                        d_clear = 1'b1; d_seq[0] = BYTE_ACK; d_len = 4'd1;
                        d_ena_set = 1'b1; d_ena = 1'b0;
                    end
                    CMD_RESEND: begin d_seq[0] = BYTE_ZERO; d_len = 4'd1; end
                    CMD_RESET: begin
                        d_clear = 1'b1; d_seq[0] = BYTE_ACK; d_seq[1] = BYTE_BAT;
                        d_len = 4'd2;
                    end
                    default: ;
                endcase
            end
        end else if (r_mode == MODE_RESET) begin
            d_clear = 1'b1; d_arg = ARG_NONE;
            d_led_we = 1'b1; d_led = 3'd0;
            d_set_we = 1'b1; d_set = 7'd1;
            d_seq[0] = BYTE_BAT; d_len = 4'd1;
        end else if (r_mode == MODE_SET) begin
            d_set_we = 1'b1; d_set = r_data[6:0];
        end
    end

    always_comb begin
        hold_we = 1'b0; hold_wa = r_key; hold_wd = d_hold;
        if (r_state == S_CLEAR) begin
            hold_we = 1'b1; hold_wa = r_clr; hold_wd = 8'h00;
        end else if (r_state == S_DECIDE) begin
            hold_we = d_hold_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= 7'd0;
            r_kbd_type <= 1'b0; r_delay <= 8'd60; r_repeat <= 6'd8;
            r_head <= '0; r_tail <= '0; r_count <= '0;
            r_arg <= ARG_NONE; r_set <= 7'd3; r_enabled <= 1'b1; r_num <= 1'b0;
            r_led <= 3'd0; r_drop <= 1'b0;
            r_len <= 4'd0; r_idx <= 4'd0; r_rdata <= 8'h00; r_rvalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KBD_TYPE: r_kbd_type <= i_cfg_data[0];
                    CFG_DELAY:    r_delay <= i_cfg_data;
                    CFG_REPEAT:   r_repeat <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 7'd1;
                    if (r_clr == 7'd127) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode; r_key <= i_key_index;
                        r_down <= i_key_down; r_data <= i_data_byte;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_seq <= d_seq; r_len <= d_len; r_idx <= 4'd0;
                    r_arg <= d_arg;
                    if (d_ena_set) r_enabled <= d_ena;
                    if (d_num_flip) r_num <= !r_num;
                    if (d_led_we) r_led <= d_led;
                    if (d_set_we) r_set <= d_set;
                    if (r_mode == MODE_RESET) r_clr <= 7'd0;
                    if (d_clear) begin
                        r_head <= '0; r_tail <= '0; r_count <= '0;
                    end
                    if (r_mode == MODE_READ && r_count != '0) begin
                        r_rdata <= r_frd; r_rvalid <= 1'b1;
                        r_tail <= (r_tail == LAST) ? '0 : r_tail + AW'(1);
                        r_count <= r_count - CW'(1);
                    end else begin
                        r_rdata <= 8'h00; r_rvalid <= 1'b0;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (r_idx != r_len) begin
                        r_idx <= r_idx + 4'd1;
                        if (r_count < FULL) begin
                            r_head <= (r_head == LAST) ? '0 : r_head + AW'(1);
                            r_count <= r_count + CW'(1);
                        end else r_drop <= 1'b1;
                    end else r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_mode == MODE_RESET) r_state <= S_CLEAR;
                        else r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
